// ===== rtl/bitmap_block_allocator_next_fit_core_macros.svh =====
// Assertion helpers for the next-fit allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_CORE_MACROS_SVH
// implication checked every edge outside reset
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/bba_pkg.sv =====
//------------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the next-fit block allocator.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package bba_pkg;
  localparam int GROUPS_DEF    = 8;
  localparam int BPG_DEF       = 1024;
  localparam int MAX_RUN_DEF   = 64;
  localparam int WORD_BITS_DEF = 64;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LWORD = 2'd2;
  localparam logic [1:0] KIND_LCNT  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ACLR  = 2'd3;

  localparam logic [1:0] REG_TOTAL = 2'd0;
  localparam logic [1:0] REG_GCNT  = 2'd1;
  localparam logic [1:0] REG_BATCH = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GSETUP, S_SCAN, S_SCANCHK, S_RUN, S_RUNCHK, S_FILL,
    S_FREE, S_FREECHK, S_DONE
  } state_t;
endpackage

// ===== rtl/bba_bitmap_mem.sv =====
//------------------------------------------------------------------------------
// bba_bitmap_mem
// Single-port used bitmap store, registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module bba_bitmap_mem #(
  parameter int WORDS = 128,
  parameter int WORD_BITS = 64,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata
);
  logic [WORD_BITS-1:0] mem [WORDS];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/bitmap_block_allocator_next_fit_core.sv =====
//------------------------------------------------------------------------------
// bitmap_block_allocator_next_fit_core
// Next-fit block allocator over per-group used bitmaps.
//------------------------------------------------------------------------------
// One request at a time. After reset a clearing pass writes every bitmap
// word (WORDS words, 128 by default) to zero before the first request.
// Allocate walks the bitmap one bit at a time through the single memory
// port, reading the word and then checking the bit. Each group visited
// takes a setup step, and each bit probed takes a read and a check.
// Growing the run reads and checks each bit tested, including the bit
// that ends it. Marking the run reads and writes each block, and a done
// step posts the result. A failing allocate over the full default span
// probes 8 x 1023 bits. Free reads the block's word, checks the bit and
// clears it if in range and used, then posts its result from the done
// step. Loads, and an allocate with no usable span, go straight to done.
// Results sit in an output register; the input is ready only when idle and the output register is empty.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_next_fit_core_macros.svh"
module bitmap_block_allocator_next_fit_core #(
  parameter int GROUPS         = bba_pkg::GROUPS_DEF,
  parameter int BITS_PER_GROUP = bba_pkg::BPG_DEF,
  parameter int MAX_RUN        = bba_pkg::MAX_RUN_DEF,
  parameter int WORD_BITS      = bba_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [6:0]  in_run_goal,
  input  logic [7:0]  in_preferred_group,
  input  logic [12:0] in_block_number,
  input  logic [6:0]  in_word_index,
  input  logic [63:0] in_word_data,
  input  logic [15:0] in_count_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [12:0] out_start_block,
  output logic [6:0]  out_run_length,
  output logic        out_sync_request
);
  localparam int CAP   = GROUPS * BITS_PER_GROUP;
  localparam int WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int BW    = $clog2(CAP + 1) + 1;        // absolute bit + margin
  localparam int GW    = $clog2(GROUPS + 1);
  localparam int GIW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LW    = $clog2(BITS_PER_GROUP + 1);  // local bit index
  localparam int RW    = $clog2(MAX_RUN + 1);

  bba_pkg::state_t state_r, state_nxt;

  logic [13:0] total_r;
  logic [3:0]  gcnt_r;
  logic [15:0] batch_r;

  logic [15:0] cnt_r [GROUPS];
  logic [LW-1:0] cur_r [GROUPS];
  logic [GIW-1:0] goalg_r;
  logic [15:0] pend_r;

  // request latch
  logic [RW-1:0] goal_r;
  logic [12:0] blk_r;

  // scan context
  logic [BW-1:0] bc_r;       // usable blocks
  logic [GW-1:0] ng_r;       // active groups
  logic [GW-1:0] gcl_r;      // clamped group count
  logic [GIW-1:0] g_r;
  logic [GW-1:0] visit_r;
  logic [LW-1:0] gb_r, from_r, i_r, end_r;
  logic          pass2_r;
  logic [RW-1:0] run_r, rmax_r, fill_r;
  logic [BW-1:0] base_r;

  logic [AW:0] clr_r;
  logic        ov_r;
  logic [1:0]  ost_r;
  logic [12:0] osb_r;
  logic [6:0]  orl_r;
  logic        osy_r;

  // memory port
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [WORD_BITS-1:0] m_wdata, m_rdata;
  logic [BW-1:0] abs_bit;
  logic [OW-1:0] bit_off;
  logic          bit_val;

  bba_bitmap_mem #(.WORDS(WORDS), .WORD_BITS(WORD_BITS)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  // usable span computation from config
  logic [BW-1:0] bc_c, gcb;
  logic [GW-1:0] gcl_c, ng_c;
  always_comb begin
    gcl_c = (32'(gcnt_r) > GROUPS) ? GW'(GROUPS) : GW'(gcnt_r);
    bc_c  = (BW'(total_r) < BW'(CAP)) ? BW'(total_r) : BW'(CAP);
    gcb   = BW'(gcl_c) * BW'(BITS_PER_GROUP);
    if (gcl_c != '0 && gcb < bc_c) bc_c = gcb;
    ng_c  = GW'((bc_c + BW'(BITS_PER_GROUP - 1)) / BITS_PER_GROUP);
  end

  // current group geometry
  logic [BW-1:0] gbase, grem;
  logic [LW-1:0] gb_c;
  always_comb begin
    gbase = BW'(g_r) * BW'(BITS_PER_GROUP);
    grem  = bc_r - gbase;
    gb_c  = (gbase >= bc_r) ? '0 :
            (grem > BW'(BITS_PER_GROUP)) ? LW'(BITS_PER_GROUP) : LW'(grem);
  end

  // block address of the bit being probed; marking walks fill_r = 1..run_r
  // over the run's offsets 0..run_r-1
  always_comb begin
    unique case (state_r)
      bba_pkg::S_FILL:   abs_bit = base_r + BW'(i_r) + BW'(fill_r) - BW'(1);
      bba_pkg::S_RUN:    abs_bit = base_r + BW'(i_r) + BW'(run_r);
      bba_pkg::S_RUNCHK: abs_bit = (fill_r != '0) ?
                                   base_r + BW'(i_r) + BW'(fill_r) - BW'(1) :
                                   base_r + BW'(i_r) + BW'(run_r);
      bba_pkg::S_FREE, bba_pkg::S_FREECHK: abs_bit = BW'(blk_r);
      default:                             abs_bit = base_r + BW'(i_r);
    endcase
    bit_off = abs_bit[OW-1:0];
    bit_val = m_rdata[bit_off];
  end

  logic [GIW-1:0] gnext;
  logic [GIW-1:0] fgrp;
  logic           free_ok;
  always_comb begin
    gnext   = (GW'(g_r) + GW'(1) >= ng_r) ? '0 : GIW'(GW'(g_r) + GW'(1));
    fgrp    = GIW'(blk_r / BITS_PER_GROUP);
    free_ok = 32'(blk_r / BITS_PER_GROUP) < 32'(gcl_r);
  end

  logic fire_in, fire_out;
  assign fire_in  = in_valid && in_ready;
  assign fire_out = out_valid && out_ready;
  assign in_ready = (state_r == bba_pkg::S_IDLE) && !ov_r;

  // memory control
  always_comb begin
    m_we    = 1'b0;
    m_addr  = AW'(abs_bit >> OW);
    m_wdata = m_rdata;
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        m_we = 1'b1; m_addr = clr_r[AW-1:0]; m_wdata = '0;
      end
      bba_pkg::S_IDLE: begin
        if (fire_in && in_kind == bba_pkg::KIND_LWORD && 32'(in_word_index) < WORDS) begin
          m_we = 1'b1; m_addr = AW'(in_word_index); m_wdata = WORD_BITS'(in_word_data);
        end
      end
      bba_pkg::S_RUNCHK: begin
        if (fill_r != '0) begin
          m_we = 1'b1; m_wdata[bit_off] = 1'b1;
        end
      end
      bba_pkg::S_FREECHK: begin
        // only an in-range block that is marked used gets cleared
        if (free_ok && bit_val) begin
          m_we = 1'b1; m_wdata[bit_off] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // saturating subtract of the run length from the current group's free count
  logic [15:0] cnt_sub;
  assign cnt_sub = (cnt_r[g_r] > 16'(run_r)) ? cnt_r[g_r] - 16'(run_r) : 16'd0;

  logic [15:0] batch_eff, pend_inc;
  assign batch_eff = (batch_r == '0) ? 16'd1 : batch_r;
  assign pend_inc  = pend_r + 16'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bba_pkg::S_CLEAR:    if (clr_r == (AW+1)'(WORDS - 1)) state_nxt = bba_pkg::S_IDLE;
      bba_pkg::S_IDLE:     if (fire_in) begin
        unique case (in_kind)
          bba_pkg::KIND_ALLOC: state_nxt = (bc_c == '0) ? bba_pkg::S_DONE : bba_pkg::S_GSETUP;
          bba_pkg::KIND_FREE:  state_nxt = bba_pkg::S_FREE;
          default:             state_nxt = bba_pkg::S_DONE;
        endcase
      end
      bba_pkg::S_GSETUP:   state_nxt = (visit_r >= ng_r) ? bba_pkg::S_DONE :
                                       (gb_c <= LW'(1)) ? bba_pkg::S_GSETUP : bba_pkg::S_SCAN;
      bba_pkg::S_SCAN:     state_nxt = bba_pkg::S_SCANCHK;
      bba_pkg::S_SCANCHK: begin
        // clear bit starts a run; otherwise keep scanning, wrap, or move on
        if (!bit_val) state_nxt = bba_pkg::S_RUN;
        else if (i_r + LW'(1) < end_r) state_nxt = bba_pkg::S_SCAN;
        else if (!pass2_r && from_r > LW'(1)) state_nxt = bba_pkg::S_SCAN;
        else state_nxt = bba_pkg::S_GSETUP;
      end
      bba_pkg::S_RUN:      state_nxt = bba_pkg::S_RUNCHK;
      bba_pkg::S_RUNCHK: begin
        if (fill_r == '0) begin
          state_nxt = (run_r < rmax_r && !bit_val) ? bba_pkg::S_RUN : bba_pkg::S_FILL;
        end else begin
          state_nxt = (32'(fill_r) < 32'(run_r)) ? bba_pkg::S_FILL : bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_FILL:     state_nxt = bba_pkg::S_RUNCHK;
      bba_pkg::S_FREE:     state_nxt = bba_pkg::S_FREECHK;
      bba_pkg::S_FREECHK:  state_nxt = bba_pkg::S_DONE;
      bba_pkg::S_DONE:     state_nxt = bba_pkg::S_IDLE;
      default:             state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLEAR;
      clr_r   <= '0;
      total_r <= 14'd8192;
      gcnt_r  <= 4'd8;
      batch_r <= 16'd1;
      goalg_r <= '0;
      pend_r  <= '0;
      ov_r    <= 1'b0;
      for (int k = 0; k < GROUPS; k++) begin
        cnt_r[k] <= '0;
        cur_r[k] <= LW'(1);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bba_pkg::REG_TOTAL: total_r <= cfg_data[13:0];
          bba_pkg::REG_GCNT:  gcnt_r  <= cfg_data[3:0];
          bba_pkg::REG_BATCH: batch_r <= cfg_data;
          default: ;
        endcase
      end
      if (fire_out) ov_r <= 1'b0;
      unique case (state_r)
        bba_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        bba_pkg::S_IDLE: if (fire_in) begin
          goal_r <= (in_run_goal == '0) ? RW'(1) :
                    (32'(in_run_goal) > MAX_RUN) ? RW'(MAX_RUN) : RW'(in_run_goal);
          blk_r  <= in_block_number;
          bc_r   <= bc_c;
          ng_r   <= ng_c;
          gcl_r  <= gcl_c;
          visit_r <= '0;
          osb_r <= '0; orl_r <= '0; osy_r <= 1'b0;
          ost_r <= (in_kind == bba_pkg::KIND_ALLOC) ? bba_pkg::ST_NOFREE :
                   ((in_kind == bba_pkg::KIND_LWORD && 32'(in_word_index) >= WORDS) ||
                    (in_kind == bba_pkg::KIND_LCNT && 32'(in_preferred_group) >= GROUPS)) ?
                   bba_pkg::ST_RANGE : bba_pkg::ST_OK;
          if (in_kind == bba_pkg::KIND_ALLOC) begin
            if (32'(in_preferred_group) < 32'(ng_c)) g_r <= GIW'(in_preferred_group);
            else if (GW'(goalg_r) < ng_c) g_r <= goalg_r;
            else g_r <= '0;
          end else if (in_kind == bba_pkg::KIND_LCNT) begin
            if (32'(in_preferred_group) < GROUPS)
              cnt_r[GIW'(in_preferred_group)] <= in_count_value;
          end
        end
        bba_pkg::S_GSETUP: begin
          base_r <= gbase;
          gb_r   <= gb_c;
          if (visit_r < ng_r && gb_c <= LW'(1)) begin
            visit_r <= visit_r + 1'b1;
            g_r <= gnext;
          end else begin
            logic [LW-1:0] f;
            f = LW'(1);
            if (GW'(g_r) < gcl_r && cur_r[g_r] >= LW'(1) && cur_r[g_r] < gb_c) f = cur_r[g_r];
            from_r  <= f;
            i_r     <= f;
            end_r   <= gb_c;
            pass2_r <= 1'b0;
          end
        end
        bba_pkg::S_SCANCHK: begin
          if (!bit_val) begin
            rmax_r  <= (32'(goal_r) < 32'(gb_r - i_r)) ? goal_r : RW'(gb_r - i_r);
            run_r   <= RW'(1);
            fill_r  <= '0;
          end else if (i_r + LW'(1) < end_r) begin
            i_r <= i_r + LW'(1);
          end else if (!pass2_r && from_r > LW'(1)) begin
            pass2_r <= 1'b1; i_r <= LW'(1); end_r <= from_r;
          end else begin
            visit_r <= visit_r + 1'b1;
            g_r <= gnext;
          end
        end
        bba_pkg::S_RUN: ;
        bba_pkg::S_RUNCHK: begin
          // first phase grows the run, second phase (fill_r != 0) marks it
          if (fill_r == '0) begin
            if (run_r < rmax_r && !bit_val) run_r <= run_r + 1'b1;
            else fill_r <= RW'(1);
          end else begin
            if (32'(fill_r) < 32'(run_r)) begin
              fill_r <= fill_r + 1'b1;
            end else begin
              cnt_r[g_r] <= cnt_sub;
              if (i_r + LW'(run_r) >= gb_r) begin
                if (GW'(g_r) < gcl_r) cur_r[g_r] <= LW'(1);
                goalg_r <= gnext;
              end else begin
                if (GW'(g_r) < gcl_r) cur_r[g_r] <= i_r + LW'(run_r);
                goalg_r <= g_r;
              end
              ost_r <= bba_pkg::ST_OK;
              osb_r <= 13'(base_r + BW'(i_r));
              orl_r <= 7'(run_r);
              if (pend_inc >= batch_eff) begin
                pend_r <= '0; osy_r <= 1'b1;
              end else pend_r <= pend_inc;
            end
          end
        end
        bba_pkg::S_FILL: ;
        bba_pkg::S_FREE: ;
        bba_pkg::S_FREECHK: begin
          if (!free_ok) ost_r <= bba_pkg::ST_RANGE;
          else if (!bit_val) ost_r <= bba_pkg::ST_ACLR;
          else begin
            cnt_r[fgrp] <= cnt_r[fgrp] + 16'd1;
            if (pend_inc >= batch_eff) begin
              pend_r <= '0; osy_r <= 1'b1;
            end else pend_r <= pend_inc;
          end
        end
        bba_pkg::S_DONE: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_start_block  = osb_r;
  assign out_run_length   = orl_r;
  assign out_sync_request = osy_r;

  `BBA_ASSERT_IMP(a_no_ready_busy, state_r != bba_pkg::S_IDLE, !in_ready, "ready while busy")
  `BBA_ASSERT_NXT(a_done_out, state_r == bba_pkg::S_DONE, out_valid, "result lost")
  `BBA_ASSERT_IMP(a_fail_zero, out_valid && out_status != bba_pkg::ST_OK, out_run_length == '0,
    "run on failure")
endmodule
